@@ hdl/wmdg_pkg.sv @@
// Package for the window-match DMA descriptor generator.
// Widths, register map, reset values and pipeline stage types.
// No dependencies; used by the top level and its checker.
package wmdg_pkg;

    // Limits of the matching unit and descriptor layout
    localparam int MAX_MASK    = 15;
    localparam int MAX_WIDTH   = 4096;
    localparam int DESC_STRIDE = 64;

    // Stream payload widths
    localparam int IDX_W     = 21;
    localparam int S_DATA_W  = 24;
    localparam int ADDR_BITS = 32;
    localparam int BCNT_W    = 3;
    localparam int M_DATA_W  = 136;
    localparam int PAD_W     = M_DATA_W - 4 * ADDR_BITS - BCNT_W;

    // Field positions in m_tdata
    localparam int OWN_LSB  = 0;
    localparam int NEXT_LSB = 32;
    localparam int SRC_LSB  = 64;
    localparam int DST_LSB  = 96;
    localparam int BCNT_LSB = 128;

    localparam logic [BCNT_W-1:0] XFER_BYTES = 3'd4;
    localparam int WORD_SH = 2;

    // Register widths and derived datapath widths
    localparam int MASK_REG_W  = 4;
    localparam int WIDTH_REG_W = 13;
    localparam int ROW_W       = $clog2(MAX_MASK + 1);
    localparam int WIDTH_W     = $clog2(MAX_WIDTH + 1);
    localparam int AREA_W      = 2 * ROW_W;
    localparam int PP_W        = AREA_W + 1;
    localparam int PROD_W      = ROW_W + WIDTH_W;
    localparam int CP_W        = IDX_W + 1;
    localparam int OFF_W       = ADDR_BITS - WORD_SH;
    localparam int PIPE_DEPTH  = IDX_W + ROW_W + 4;

    // APB register map
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_MASK_SIZE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPACE_WIDTH = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DESC_BASE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SPACE_BASE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MASK_BASE   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RESULT_BASE = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_UNIT_BASE   = 3'd6;

    // Register reset values
    localparam logic [MASK_REG_W-1:0]  RST_MASK_SIZE   = 4'd3;
    localparam logic [WIDTH_REG_W-1:0] RST_SPACE_WIDTH = 13'd18;
    localparam logic [ADDR_BITS-1:0]   RST_DESC_BASE   = 32'h1000_0000;
    localparam logic [ADDR_BITS-1:0]   RST_SPACE_BASE  = 32'h1100_0000;
    localparam logic [ADDR_BITS-1:0]   RST_MASK_BASE   = 32'h1110_0000;
    localparam logic [ADDR_BITS-1:0]   RST_RESULT_BASE = 32'h1120_0000;
    localparam logic [ADDR_BITS-1:0]   RST_UNIT_BASE   = 32'h7600_0000;

    // What a slot within a pixel's group does
    typedef enum logic [1:0] {
        SLOT_SPACE,
        SLOT_MASK,
        SLOT_RESULT
    } slot_kind_t;

    // Divider stage: index split into pixel and slot, one quotient bit a stage
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
        logic [PP_W-1:0]  rem;
        logic [IDX_W-1:0] quot;
    } div_t;

    // Classify and row-divide stages
    typedef struct packed {
        logic [ADDR_BITS-1:0] own;
        logic                 last;
        logic [IDX_W-1:0]     pixel;
        logic [PP_W-1:0]      slot;
        slot_kind_t           kind;
        logic [AREA_W-1:0]    k;
        logic [AREA_W-1:0]    rrem;
        logic [ROW_W-1:0]     row;
    } mid_t;

    // Multiply stage
    typedef struct packed {
        logic [ADDR_BITS-1:0] own;
        logic [ADDR_BITS-1:0] next;
        logic [IDX_W-1:0]     pixel;
        logic [PP_W-1:0]      slot;
        slot_kind_t           kind;
        logic [AREA_W-1:0]    k;
        logic [PROD_W-1:0]    rw;
        logic [CP_W-1:0]      cp;
    } mul_t;

    // Offset selection stage
    typedef struct packed {
        logic [ADDR_BITS-1:0] own;
        logic [ADDR_BITS-1:0] next;
        logic [ADDR_BITS-1:0] src_base;
        logic [OFF_W-1:0]     src_off;
        logic [ADDR_BITS-1:0] dst_base;
        logic [OFF_W-1:0]     dst_off;
    } sum_t;

    // Finished descriptor
    typedef struct packed {
        logic [ADDR_BITS-1:0] own;
        logic [ADDR_BITS-1:0] next;
        logic [ADDR_BITS-1:0] src;
        logic [ADDR_BITS-1:0] dst;
    } desc_t;

endpackage

@@ hdl/window_match_dma_descriptor_gen.sv @@
// Window-match DMA descriptor generator, top level.
// Depends on wmdg_pkg for widths, register map and stage types.
//
// Usage:
//   s_ channel: one descriptor number per transaction (index in s_tdata,
//   last-of-chain flag in s_tlast). m_ channel: one descriptor per
//   transaction (own, next, source, destination addresses, byte count).
//   APB port sets window side, row width and the five base addresses;
//   registers must be written only while the block is empty (not enforced).
// Throughput: one descriptor per cycle while the skid register is empty.
//   The pixel/slot split is a restoring divider by 2*m*m+1 unrolled into
//   21 stages (one quotient bit each), then a slot classify stage, a
//   4-stage row divider by m, a multiply stage, an offset select stage
//   and the final address adders.
// Reset: aresetn (synchronous) empties the pipeline and the output
//   stages and loads the register defaults.
// Stall: the output register is backed by a skid register. The pipeline
//   keeps moving while the skid register is empty; once it fills, the
//   whole pipeline freezes and s_tready drops until m_ takes a result.
module window_match_dma_descriptor_gen (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // s_tdata: [20:0] index, [23:21] zero
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [wmdg_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic                                 s_tlast,
    // m_tdata: [31:0] own_address, [63:32] next_address,
    //          [95:64] source_address, [127:96] dest_address,
    //          [130:128] byte_count, [135:131] zero
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [wmdg_pkg::M_DATA_W-1:0]        m_tdata,
    // APB configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wmdg_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [wmdg_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [wmdg_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    // Configuration registers
    logic [wmdg_pkg::MASK_REG_W-1:0]  mask_size_reg;
    logic [wmdg_pkg::WIDTH_REG_W-1:0] space_width_reg;
    logic [wmdg_pkg::ADDR_BITS-1:0]   desc_base_reg;
    logic [wmdg_pkg::ADDR_BITS-1:0]   space_base_reg;
    logic [wmdg_pkg::ADDR_BITS-1:0]   mask_base_reg;
    logic [wmdg_pkg::ADDR_BITS-1:0]   result_base_reg;
    logic [wmdg_pkg::ADDR_BITS-1:0]   unit_base_reg;

    logic                             cfg_wr;
    logic [wmdg_pkg::REG_IDX_W-1:0]   cfg_idx;

    // Values derived from configuration
    logic [wmdg_pkg::ROW_W-1:0]       m_sat;
    logic [wmdg_pkg::WIDTH_W-1:0]     w_sat;
    logic [wmdg_pkg::AREA_W-1:0]      area;
    logic [wmdg_pkg::PP_W-1:0]        per_pixel;

    // Pipeline
    logic                             en;
    logic [wmdg_pkg::PIPE_DEPTH-1:0]  vld_reg;
    wmdg_pkg::div_t                   div_src  [wmdg_pkg::IDX_W];
    wmdg_pkg::div_t                   div_next [wmdg_pkg::IDX_W];
    wmdg_pkg::div_t                   div_reg  [wmdg_pkg::IDX_W];
    wmdg_pkg::mid_t                   mid_next [wmdg_pkg::ROW_W+1];
    wmdg_pkg::mid_t                   mid_reg  [wmdg_pkg::ROW_W+1];
    wmdg_pkg::mul_t                   mul_next;
    wmdg_pkg::mul_t                   mul_reg;
    wmdg_pkg::sum_t                   sum_next;
    wmdg_pkg::sum_t                   sum_reg;
    wmdg_pkg::desc_t                  fin_next;
    wmdg_pkg::desc_t                  fin_reg;

    // Output register and skid register
    logic                             out_valid_reg;
    wmdg_pkg::desc_t                  out_reg;
    logic                             skid_valid_reg;
    wmdg_pkg::desc_t                  skid_reg;

    // ------------------------------------------------------------------
    // APB port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[wmdg_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_size_reg   <= wmdg_pkg::RST_MASK_SIZE;
            space_width_reg <= wmdg_pkg::RST_SPACE_WIDTH;
            desc_base_reg   <= wmdg_pkg::RST_DESC_BASE;
            space_base_reg  <= wmdg_pkg::RST_SPACE_BASE;
            mask_base_reg   <= wmdg_pkg::RST_MASK_BASE;
            result_base_reg <= wmdg_pkg::RST_RESULT_BASE;
            unit_base_reg   <= wmdg_pkg::RST_UNIT_BASE;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                wmdg_pkg::REG_MASK_SIZE:
                    mask_size_reg <= pwdata[wmdg_pkg::MASK_REG_W-1:0];
                wmdg_pkg::REG_SPACE_WIDTH:
                    space_width_reg <= pwdata[wmdg_pkg::WIDTH_REG_W-1:0];
                wmdg_pkg::REG_DESC_BASE:   desc_base_reg   <= pwdata;
                wmdg_pkg::REG_SPACE_BASE:  space_base_reg  <= pwdata;
                wmdg_pkg::REG_MASK_BASE:   mask_base_reg   <= pwdata;
                wmdg_pkg::REG_RESULT_BASE: result_base_reg <= pwdata;
                wmdg_pkg::REG_UNIT_BASE:   unit_base_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb begin
        unique case (cfg_idx)
            wmdg_pkg::REG_MASK_SIZE:
                prdata = wmdg_pkg::APB_DATA_W'(mask_size_reg);
            wmdg_pkg::REG_SPACE_WIDTH:
                prdata = wmdg_pkg::APB_DATA_W'(space_width_reg);
            wmdg_pkg::REG_DESC_BASE:   prdata = desc_base_reg;
            wmdg_pkg::REG_SPACE_BASE:  prdata = space_base_reg;
            wmdg_pkg::REG_MASK_BASE:   prdata = mask_base_reg;
            wmdg_pkg::REG_RESULT_BASE: prdata = result_base_reg;
            wmdg_pkg::REG_UNIT_BASE:   prdata = unit_base_reg;
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Saturated window side and row width, slots per pixel
    always_comb begin
        m_sat = (32'(mask_size_reg) > wmdg_pkg::MAX_MASK)
              ? wmdg_pkg::ROW_W'(wmdg_pkg::MAX_MASK)
              : wmdg_pkg::ROW_W'(mask_size_reg);
        w_sat = (32'(space_width_reg) > wmdg_pkg::MAX_WIDTH)
              ? wmdg_pkg::WIDTH_W'(wmdg_pkg::MAX_WIDTH)
              : wmdg_pkg::WIDTH_W'(space_width_reg);
        area      = wmdg_pkg::AREA_W'(m_sat) * wmdg_pkg::AREA_W'(m_sat);
        per_pixel = {area, 1'b1};
    end

    // Pipeline advances while the skid register is empty
    assign en       = !skid_valid_reg;
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[wmdg_pkg::PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // Divider: index / (2*m*m+1), one quotient bit per stage
    always_comb begin
        logic [wmdg_pkg::PP_W:0] shifted;
        logic                    take;
        div_src[0].idx  = s_tdata[wmdg_pkg::IDX_W-1:0];
        div_src[0].last = s_tlast;
        div_src[0].rem  = '0;
        div_src[0].quot = '0;
        for (int i = 1; i < wmdg_pkg::IDX_W; i++) begin
            div_src[i] = div_reg[i-1];
        end
        for (int i = 0; i < wmdg_pkg::IDX_W; i++) begin
            shifted = {div_src[i].rem, div_src[i].idx[wmdg_pkg::IDX_W-1-i]};
            take    = (shifted >= {1'b0, per_pixel});
            div_next[i].idx  = div_src[i].idx;
            div_next[i].last = div_src[i].last;
            div_next[i].rem  = take ? wmdg_pkg::PP_W'(shifted - {1'b0, per_pixel})
                                    : wmdg_pkg::PP_W'(shifted);
            div_next[i].quot = {div_src[i].quot[wmdg_pkg::IDX_W-2:0], take};
        end
    end

    // ------------------------------------------------------------------
    // Classify the slot, then row = slot / m, one bit per stage
    always_comb begin
        logic [wmdg_pkg::AREA_W-1:0] dv;
        wmdg_pkg::div_t              d;
        d = div_reg[wmdg_pkg::IDX_W-1];
        mid_next[0].own   = desc_base_reg
                          + wmdg_pkg::ADDR_BITS'(d.idx)
                          * wmdg_pkg::ADDR_BITS'(wmdg_pkg::DESC_STRIDE);
        mid_next[0].last  = d.last;
        mid_next[0].pixel = d.quot;
        mid_next[0].slot  = d.rem;
        if (d.rem < wmdg_pkg::PP_W'(area)) begin
            mid_next[0].kind = wmdg_pkg::SLOT_SPACE;
        end else if (d.rem < {area, 1'b0}) begin
            mid_next[0].kind = wmdg_pkg::SLOT_MASK;
        end else begin
            mid_next[0].kind = wmdg_pkg::SLOT_RESULT;
        end
        mid_next[0].k    = wmdg_pkg::AREA_W'(d.rem - wmdg_pkg::PP_W'(area));
        mid_next[0].rrem = wmdg_pkg::AREA_W'(d.rem);
        mid_next[0].row  = '0;
        // Quotient is below 2^ROW_W: compare against m shifted down bit by bit
        for (int j = 0; j < wmdg_pkg::ROW_W; j++) begin
            dv = wmdg_pkg::AREA_W'(m_sat) << (wmdg_pkg::ROW_W - 1 - j);
            mid_next[j+1] = mid_reg[j];
            if (mid_reg[j].rrem >= dv) begin
                mid_next[j+1].rrem = mid_reg[j].rrem - dv;
                mid_next[j+1].row[wmdg_pkg::ROW_W-1-j] = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Row times row width, pixel plus column, next pointer
    always_comb begin
        wmdg_pkg::mid_t mr;
        mr = mid_reg[wmdg_pkg::ROW_W];
        mul_next.own   = mr.own;
        mul_next.next  = mr.last ? desc_base_reg
                       : mr.own + wmdg_pkg::ADDR_BITS'(wmdg_pkg::DESC_STRIDE);
        mul_next.pixel = mr.pixel;
        mul_next.slot  = mr.slot;
        mul_next.kind  = mr.kind;
        mul_next.k     = mr.k;
        mul_next.rw    = wmdg_pkg::PROD_W'(mr.row) * wmdg_pkg::PROD_W'(w_sat);
        mul_next.cp    = wmdg_pkg::CP_W'(mr.pixel) + wmdg_pkg::CP_W'(mr.rrem);
    end

    // Word offsets and bases per slot kind
    always_comb begin
        sum_next.own  = mul_reg.own;
        sum_next.next = mul_reg.next;
        case (mul_reg.kind)
            wmdg_pkg::SLOT_SPACE: begin
                sum_next.src_base = space_base_reg;
                sum_next.src_off  = wmdg_pkg::OFF_W'(mul_reg.rw)
                                  + wmdg_pkg::OFF_W'(mul_reg.cp);
                sum_next.dst_base = unit_base_reg;
                sum_next.dst_off  = wmdg_pkg::OFF_W'(mul_reg.slot);
            end
            wmdg_pkg::SLOT_MASK: begin
                // column + row*m collapses to the mask word number
                sum_next.src_base = mask_base_reg;
                sum_next.src_off  = wmdg_pkg::OFF_W'(mul_reg.k);
                sum_next.dst_base = unit_base_reg;
                sum_next.dst_off  = wmdg_pkg::OFF_W'(mul_reg.slot);
            end
            default: begin
                sum_next.src_base = unit_base_reg;
                sum_next.src_off  = '0;
                sum_next.dst_base = result_base_reg;
                sum_next.dst_off  = wmdg_pkg::OFF_W'(mul_reg.pixel);
            end
        endcase
    end

    // Final byte addresses
    always_comb begin
        fin_next.own  = sum_reg.own;
        fin_next.next = sum_reg.next;
        fin_next.src  = sum_reg.src_base + {sum_reg.src_off, 2'b00};
        fin_next.dst  = sum_reg.dst_base + {sum_reg.dst_off, 2'b00};
    end

    // Pipeline payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg <= div_next;
            mid_reg <= mid_next;
            mul_reg <= mul_next;
            sum_reg <= sum_next;
            fin_reg <= fin_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid register behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= vld_reg[wmdg_pkg::PIPE_DEPTH-1];
            end
        end else if (en && vld_reg[wmdg_pkg::PIPE_DEPTH-1]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : fin_reg;
        end else if (en) begin
            skid_reg <= fin_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{wmdg_pkg::PAD_W{1'b0}}, wmdg_pkg::XFER_BYTES,
                       out_reg.dst, out_reg.src, out_reg.next, out_reg.own};

endmodule

@@ hdl/wmdg_chk.sv @@
// Port-level checker for the window-match DMA descriptor generator.
// Depends on wmdg_pkg; bound to the top level at the end of this file.
module wmdg_chk (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wmdg_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          pready
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every descriptor moves one word
    a_byte_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[wmdg_pkg::BCNT_LSB+wmdg_pkg::BCNT_W-1:wmdg_pkg::BCNT_LSB]
                     == wmdg_pkg::XFER_BYTES)
        else $error("byte count is not one word");

    // Input backpressure only while a result waits at the output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // Reset leaves the block empty and ready
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> s_tready && !m_tvalid)
        else $error("block not empty after reset");

    // Configuration port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind window_match_dma_descriptor_gen wmdg_chk u_wmdg_chk (.*);

@@ tb/window_match_dma_descriptor_gen_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the window-match DMA descriptor generator.
// Drives descriptor numbers and APB settings, predicts every descriptor and checks m_ output.
// Depends on wmdg_pkg and window_match_dma_descriptor_gen.
module window_match_dma_descriptor_gen_tb;

    localparam int HALF_PERIOD = 6;
    localparam int IDX_TOP     = (1 << wmdg_pkg::IDX_W) - 1;
    localparam int MAX_REPORTS = 40;

    // register index past the end of the map; writes must be ignored
    localparam logic [wmdg_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // one request on s_: descriptor number plus end-of-chain flag
    typedef struct {
        logic [wmdg_pkg::IDX_W-1:0] index;
        logic                       is_last;
    } desc_req_t;

    // one descriptor as seen on m_tdata
    typedef struct packed {
        logic [wmdg_pkg::ADDR_BITS-1:0] own;
        logic [wmdg_pkg::ADDR_BITS-1:0] next;
        logic [wmdg_pkg::ADDR_BITS-1:0] src;
        logic [wmdg_pkg::ADDR_BITS-1:0] dst;
        logic [wmdg_pkg::BCNT_W-1:0]    bcnt;
    } wm_desc_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [wmdg_pkg::S_DATA_W-1:0]   s_tdata  = '0;
    logic                            s_tlast  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [wmdg_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [wmdg_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [wmdg_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [wmdg_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // shadow copy of the register file
    logic [wmdg_pkg::MASK_REG_W-1:0]  cfg_mask_size   = wmdg_pkg::RST_MASK_SIZE;
    logic [wmdg_pkg::WIDTH_REG_W-1:0] cfg_space_width = wmdg_pkg::RST_SPACE_WIDTH;
    logic [wmdg_pkg::ADDR_BITS-1:0]   cfg_desc_base   = wmdg_pkg::RST_DESC_BASE;
    logic [wmdg_pkg::ADDR_BITS-1:0]   cfg_space_base  = wmdg_pkg::RST_SPACE_BASE;
    logic [wmdg_pkg::ADDR_BITS-1:0]   cfg_mask_base   = wmdg_pkg::RST_MASK_BASE;
    logic [wmdg_pkg::ADDR_BITS-1:0]   cfg_result_base = wmdg_pkg::RST_RESULT_BASE;
    logic [wmdg_pkg::ADDR_BITS-1:0]   cfg_unit_base   = wmdg_pkg::RST_UNIT_BASE;

    desc_req_t desc_reqs[$];
    wm_desc_t  want_descs[$];
    desc_req_t drv_req;
    wm_desc_t  want_desc;

    bit calm_run         = 1'b0;
    int fail_count       = 0;
    int reqs_accepted    = 0;
    int descs_checked    = 0;
    int settings_applied = 1;

    window_match_dma_descriptor_gen dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Descriptor for one request under the current register settings
    function automatic wm_desc_t predict_descriptor(
        input logic [wmdg_pkg::IDX_W-1:0] index,
        input logic is_last);
        logic [31:0] side, width, area, per_pixel, pixel, slot, row, col, k, idx32;
        wm_desc_t d;
        side      = (cfg_mask_size > wmdg_pkg::MAX_MASK) ? 32'(wmdg_pkg::MAX_MASK)
                                                         : 32'(cfg_mask_size);
        width     = (cfg_space_width > wmdg_pkg::MAX_WIDTH) ? 32'(wmdg_pkg::MAX_WIDTH)
                                                            : 32'(cfg_space_width);
        idx32     = 32'(index);
        area      = side * side;
        per_pixel = 2 * area + 1;
        pixel     = idx32 / per_pixel;
        slot      = idx32 % per_pixel;
        d.own     = cfg_desc_base + idx32 * 32'(wmdg_pkg::DESC_STRIDE);
        d.next    = is_last ? cfg_desc_base : d.own + 32'(wmdg_pkg::DESC_STRIDE);
        d.bcnt    = wmdg_pkg::XFER_BYTES;
        if (slot < area) begin
            // window word of the left space, moved right by the pixel number
            row   = slot / side;
            col   = slot % side;
            d.src = cfg_space_base + col * 4 + row * width * 4 + pixel * 4;
            d.dst = cfg_unit_base + slot * 4;
        end else if (slot < 2 * area) begin
            // fixed mask word
            k     = slot - area;
            row   = k / side;
            col   = k % side;
            d.src = cfg_mask_base + col * 4 + row * side * 4;
            d.dst = cfg_unit_base + slot * 4;
        end else begin
            // result move, also every slot when the window side is zero
            d.src = cfg_unit_base;
            d.dst = cfg_result_base + pixel * 4;
        end
        return d;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
        end
    endtask

    // Request driver: pulls from desc_reqs, holds tvalid until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (desc_reqs.size() != 0 && (calm_run || $urandom_range(0, 99) >= 25)) begin
                drv_req = desc_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{(wmdg_pkg::S_DATA_W - wmdg_pkg::IDX_W){1'b0}}, drv_req.index};
                s_tlast  <= drv_req.is_last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side backpressure
    always @(posedge aclk) begin
        m_tready <= aresetn && (calm_run || $urandom_range(0, 99) >= 25);
    end

    // Monitor: predict on s_ transactions, compare on m_ transactions
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want_descs.push_back(predict_descriptor(s_tdata[wmdg_pkg::IDX_W-1:0],
                                                        s_tlast));
                reqs_accepted++;
            end
            if (m_tvalid && m_tready) begin
                if (want_descs.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("unexpected descriptor: own 0x%08h",
                               m_tdata[wmdg_pkg::OWN_LSB +: 32]);
                end else begin
                    want_desc = want_descs.pop_front();
                    descs_checked++;
                    check_field("own_address", want_desc.own,
                                m_tdata[wmdg_pkg::OWN_LSB +: 32]);
                    check_field("next_address", want_desc.next,
                                m_tdata[wmdg_pkg::NEXT_LSB +: 32]);
                    check_field("source_address", want_desc.src,
                                m_tdata[wmdg_pkg::SRC_LSB +: 32]);
                    check_field("dest_address", want_desc.dst,
                                m_tdata[wmdg_pkg::DST_LSB +: 32]);
                    check_field("byte_count", 32'(want_desc.bcnt),
                                32'(m_tdata[wmdg_pkg::BCNT_LSB +: wmdg_pkg::BCNT_W]));
                    check_field("pad", 32'd0,
                                32'(m_tdata[wmdg_pkg::M_DATA_W-1:
                                            wmdg_pkg::BCNT_LSB+wmdg_pkg::BCNT_W]));
                end
            end
        end
    end

    // APB write: setup cycle, access cycle, then update the shadow copy
    task automatic apb_write(input logic [wmdg_pkg::REG_IDX_W-1:0] reg_idx,
                             input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            wmdg_pkg::REG_MASK_SIZE:   cfg_mask_size   = value[wmdg_pkg::MASK_REG_W-1:0];
            wmdg_pkg::REG_SPACE_WIDTH: cfg_space_width = value[wmdg_pkg::WIDTH_REG_W-1:0];
            wmdg_pkg::REG_DESC_BASE:   cfg_desc_base   = value;
            wmdg_pkg::REG_SPACE_BASE:  cfg_space_base  = value;
            wmdg_pkg::REG_MASK_BASE:   cfg_mask_base   = value;
            wmdg_pkg::REG_RESULT_BASE: cfg_result_base = value;
            wmdg_pkg::REG_UNIT_BASE:   cfg_unit_base   = value;
            default: ;
        endcase
    endtask

    // Full register set; upper bits of the narrow registers carry noise
    task automatic apply_setting(input logic [3:0] side, input logic [12:0] width,
                                 input logic [31:0] dbase, input logic [31:0] sbase,
                                 input logic [31:0] mbase, input logic [31:0] rbase,
                                 input logic [31:0] ubase);
        apb_write(wmdg_pkg::REG_MASK_SIZE, ($urandom & 32'hFFFF_FFF0) | 32'(side));
        apb_write(wmdg_pkg::REG_SPACE_WIDTH, ($urandom & 32'hFFFF_E000) | 32'(width));
        apb_write(wmdg_pkg::REG_DESC_BASE, dbase);
        apb_write(wmdg_pkg::REG_SPACE_BASE, sbase);
        apb_write(wmdg_pkg::REG_MASK_BASE, mbase);
        apb_write(wmdg_pkg::REG_RESULT_BASE, rbase);
        apb_write(wmdg_pkg::REG_UNIT_BASE, ubase);
        settings_applied++;
    endtask

    task automatic push_req(input int index, input bit is_last);
        desc_req_t req;
        req.index   = index[wmdg_pkg::IDX_W-1:0];
        req.is_last = is_last;
        desc_reqs.push_back(req);
    endtask

    // Wait until every request has gone in and every descriptor has come out;
    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_drained();
        do @(negedge aclk);
        while (desc_reqs.size() != 0 || s_tvalid || want_descs.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly chains of consecutive descriptors placed near slot boundaries,
    // the rest single requests anywhere in the index range
    task automatic queue_random_reqs(input int count);
        int queued, area, per_pixel, pixel_top, chain_len, offset, start, i;
        queued    = 0;
        area      = int'(cfg_mask_size) * int'(cfg_mask_size);
        per_pixel = 2 * area + 1;
        pixel_top = (IDX_TOP - 64) / per_pixel;
        while (queued < count) begin
            if ($urandom_range(0, 99) < 30) begin
                push_req(int'($urandom & IDX_TOP), 1'($urandom_range(0, 1)));
                queued++;
            end else begin
                chain_len = $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0: offset = 0;
                    1: offset = area - 2;
                    2: offset = 2 * area - 2;
                    default: offset = $urandom_range(0, per_pixel - 1);
                endcase
                if (offset < 0) offset = 0;
                if ($urandom_range(0, 4) == 0)
                    start = offset;
                else
                    start = $urandom_range(0, pixel_top) * per_pixel + offset;
                if (start + chain_len > IDX_TOP + 1) start = IDX_TOP + 1 - chain_len;
                for (i = 0; i < chain_len; i++)
                    push_req(start + i, i == chain_len - 1);
                queued += chain_len;
            end
        end
    endtask

    initial begin
        int phase;
        logic [12:0] width;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests at reset settings (side 3, 19 slots a pixel)
        push_req(0, 1'b0);
        push_req(1, 1'b0);
        push_req(3, 1'b0);
        push_req(8, 1'b0);
        push_req(9, 1'b0);
        push_req(17, 1'b0);
        push_req(18, 1'b1);
        push_req(19, 1'b0);
        push_req(37, 1'b0);
        push_req(38, 1'b0);
        push_req(0, 1'b1);
        push_req(IDX_TOP, 1'b1);
        push_req(IDX_TOP, 1'b0);
        push_req(IDX_TOP - 1, 1'b0);
        push_req(1 << (wmdg_pkg::IDX_W - 1), 1'b0);
        push_req(32'h0015_5555, 1'b1);
        push_req(32'h000A_AAAA, 1'b0);
        wait_drained();

        // Smallest window and row, random bases
        apply_setting(4'd1, 13'd1, $urandom, $urandom, $urandom, $urandom, $urandom);
        queue_random_reqs(220);
        wait_drained();

        // Largest values everywhere: row width saturates, sums wrap
        apply_setting(4'd15, 13'h1FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(0, 1'b0);
        push_req(224, 1'b0);
        push_req(225, 1'b0);
        push_req(449, 1'b0);
        push_req(450, 1'b1);
        push_req(451, 1'b0);
        queue_random_reqs(220);
        wait_drained();

        // Zero window side and zero row width; an out-of-map write is dropped
        apply_setting(4'd0, 13'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        apb_write(REG_UNUSED, $urandom);
        queue_random_reqs(200);
        wait_drained();

        // Back-to-back stretch: no idling on either side
        calm_run = 1'b1;
        apply_setting(4'($urandom_range(1, 15)), 13'($urandom_range(1, 4096)),
                      $urandom, $urandom, $urandom, $urandom, $urandom);
        queue_random_reqs(250);
        wait_drained();
        calm_run = 1'b0;

        // Random settings, row width around the saturation point too
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: width = 13'd4096;
                1: width = 13'd4097;
                2: width = 13'($urandom_range(1, 64));
                default: width = 13'($urandom_range(0, 8191));
            endcase
            apply_setting(4'($urandom_range(0, 15)), width, $urandom, $urandom,
                          $urandom, $urandom, $urandom);
            queue_random_reqs(215);
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        if (want_descs.size() != 0) fail_count++;
        $display("Checked %0d descriptors for %0d requests over %0d register settings,",
                 descs_checked, reqs_accepted, settings_applied);
        $display("window sides 0 to 15, row widths 0 to 8191, wrapping bases.");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #3_600_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
